>>> sv/wcd_pkg.sv
// ----------------------------------------------------------------------------
// wcd_pkg
// Shared types and constants for the warm-up and confirm-count debouncer.
// ----------------------------------------------------------------------------
package wcd_pkg;

  // Width of the equal-sample counter and of the confirm count register.
  localparam int COUNT_BITS = 16;
  localparam int MS_BITS    = 32;
  localparam int SEQ_BITS   = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WARMUP_WINDOW = 2'd2;

  // Register reset values.
  localparam logic                  RST_ACTIVE_LEVEL  = 1'b1;
  localparam logic [COUNT_BITS-1:0] RST_CONFIRM_COUNT = COUNT_BITS'(3);
  localparam logic [MS_BITS-1:0]    RST_WARMUP_WINDOW = MS_BITS'(60000);

  // Qualified state of the alarm line.
  typedef enum logic [1:0] {
    MODE_WARMUP = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_ALARM  = 2'd2
  } mode_t;

endpackage

>>> sv/warmup_confirm_debouncer.sv
// ----------------------------------------------------------------------------
// warmup_confirm_debouncer
// Qualifies a sampled alarm line with a warm-up window and a confirm count.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction carries one sample of the alarm line (in_sensor_level)
// and the milliseconds elapsed since start (in_ms_since_start). Every input
// transaction produces exactly one output transaction carrying the qualified
// state, the alarm flag, the equal-sample count, a valid flag, a sequence
// number that starts at 1 and the sampled level.
// The block is a two-stage pipeline: an input register, then one pass of
// short logic that updates the debounce state and loads the output register.
// The result is presented once the output register loads it, and one
// sample per cycle is sustained while the receiver does not stall.
// When the receiver holds out_stall, the output register holds its
// transaction; one more sample is still taken into the input register, and
// only then does in_stall rise.
// Reset (rst_n low, synchronous) empties both stages, clears the sequence
// counter and the count, returns to the warming-up state and restores the
// configuration registers to their defaults. The configuration port is always
// ready and must only be written while no sample is in flight.
// ----------------------------------------------------------------------------
module warmup_confirm_debouncer
  import wcd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Sample channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_sensor_level,
  input  logic [MS_BITS-1:0]       in_ms_since_start,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_qualified_state,
  output logic                     out_alarm_flag,
  output logic [COUNT_BITS-1:0]    out_stable_count_out,
  output logic                     out_result_valid,
  output logic [SEQ_BITS-1:0]      out_sequence_number,
  output logic                     out_level_echo,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Configuration registers.
  logic                  active_level_r;
  logic [COUNT_BITS-1:0] confirm_count_r;
  logic [MS_BITS-1:0]    warmup_window_r;

  // Input stage.
  logic               s1_valid_r;
  logic               s1_level_r;
  logic [MS_BITS-1:0] s1_ms_r;

  // Debounce state. These registers also serve as the output register, so
  // they only change when a new result is loaded.
  mode_t                 mode_r, mode_nxt;
  logic                  last_alarm_r, last_alarm_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [SEQ_BITS-1:0]   seq_r;
  logic                  level_echo_r;
  logic                  out_valid_r;

  logic in_fire;
  logic advance;
  logic load_out;
  logic alarm;
  logic warming;

  // The output register can take a new result when it is empty or its
  // current result is leaving this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign load_out = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r  <= RST_ACTIVE_LEVEL;
      confirm_count_r <= RST_CONFIRM_COUNT;
      warmup_window_r <= RST_WARMUP_WINDOW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE_LEVEL:  active_level_r  <= cfg_data[0];
        CFG_CONFIRM_COUNT: confirm_count_r <= cfg_data[COUNT_BITS-1:0];
        CFG_WARMUP_WINDOW: warmup_window_r <= cfg_data[MS_BITS-1:0];
        default: ;  // Writes beyond the register list are dropped.
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (load_out) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_level_r <= in_sensor_level;
      s1_ms_r    <= in_ms_since_start;
    end
  end

  assign alarm   = (s1_level_r == active_level_r);
  assign warming = (warmup_window_r != '0) && (s1_ms_r < warmup_window_r);

  // Next-state logic for the debounce state.
  always_comb begin
    mode_nxt       = mode_r;
    last_alarm_nxt = last_alarm_r;
    count_nxt      = count_r;
    if (warming) begin
      // Inside the window: hold warm-up with a cleared count, keep the flag.
      mode_nxt  = MODE_WARMUP;
      count_nxt = '0;
    end else begin
      if (mode_r == MODE_WARMUP) begin
        // First sample after warm-up adopts the level at once.
        mode_nxt       = alarm ? MODE_ALARM : MODE_NORMAL;
        last_alarm_nxt = alarm;
        count_nxt      = confirm_count_r;
      end else if (alarm == last_alarm_r) begin
        if (count_r < confirm_count_r) begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
      end else begin
        last_alarm_nxt = alarm;
        count_nxt      = COUNT_BITS'(1);
      end
      if (count_nxt >= confirm_count_r) begin
        mode_nxt = alarm ? MODE_ALARM : MODE_NORMAL;
      end
    end
  end

  // State and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_WARMUP;
      last_alarm_r <= 1'b0;
      count_r      <= '0;
      seq_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (load_out) begin
        mode_r       <= mode_nxt;
        last_alarm_r <= last_alarm_nxt;
        count_r      <= count_nxt;
        seq_r        <= seq_r + SEQ_BITS'(1);
        out_valid_r  <= 1'b1;
      end else if (advance) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      level_echo_r <= s1_level_r;
    end
  end

  // Output decode from the registered state.
  always_comb begin
    out_valid            = out_valid_r;
    out_qualified_state  = mode_r;
    out_alarm_flag       = (mode_r == MODE_ALARM);
    out_result_valid     = (mode_r != MODE_WARMUP);
    out_stable_count_out = count_r;
    out_sequence_number  = seq_r;
    out_level_echo       = level_echo_r;
  end

endmodule

>>> sv/wcd_checker.sv
// ----------------------------------------------------------------------------
// wcd_checker
// Port-level assertions for the warm-up and confirm-count debouncer.
// ----------------------------------------------------------------------------
module wcd_checker
  import wcd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            out_qualified_state,
  input logic                  out_alarm_flag,
  input logic [COUNT_BITS-1:0] out_stable_count_out,
  input logic                  out_result_valid,
  input logic [SEQ_BITS-1:0]   out_sequence_number
);

  // A stalled result keeps its sequence number.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sequence_number))
    else $error("stalled result changed");

  // Results leave in order with no gap or repeat in the sequence.
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=>
      !out_valid || out_sequence_number == $past(out_sequence_number) + SEQ_BITS'(1))
    else $error("sequence number skipped or repeated");

  // A warming-up result carries no alarm and a zero count.
  a_warmup_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_valid |->
      out_stable_count_out == '0 && !out_alarm_flag &&
      out_qualified_state == MODE_WARMUP)
    else $error("warm-up result has stray fields");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind warmup_confirm_debouncer wcd_checker u_wcd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_qualified_state  (out_qualified_state),
  .out_alarm_flag       (out_alarm_flag),
  .out_stable_count_out (out_stable_count_out),
  .out_result_valid     (out_result_valid),
  .out_sequence_number  (out_sequence_number)
);
